// ===== hw/rtl/psort_pkg.sv =====
// Shared types and constants of the coincidence sorter.
`default_nettype none
package psort_pkg;

   localparam int unsigned ENERGY_BITS = 12;
   localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = 12'hFFF;
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned RES_BITS = 5;

   localparam logic [2:0] REG_ENERGY_LOW = 3'd0;
   localparam logic [2:0] REG_ENERGY_HIGH = 3'd1;
   localparam logic [2:0] REG_COINC_WINDOW = 3'd2;
   localparam logic [2:0] REG_PILEUP_WINDOW = 3'd3;
   localparam logic [2:0] REG_MERGE_BY_BLOCK = 3'd4;
   localparam logic [2:0] REG_RING_GATE_EN = 3'd5;
   localparam logic [2:0] REG_MAX_RING_DIFF = 3'd6;

   typedef struct packed {
      logic [11:0] energy_low;
      logic [11:0] energy_high;
      logic [23:0] coinc_window;
      logic [23:0] pileup_window;
      logic        merge_by_block;
      logic        ring_gate_enable;
      logic [7:0]  max_ring_diff;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_EVAL,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_APPEND
   } state_type;

   typedef enum logic [1:0] {
      PH_SCAN,
      PH_FLUSH,
      PH_EVICT,
      PH_SHIFT
   } phase_type;

endpackage
`default_nettype wire

// ===== hw/rtl/psort_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module psort_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(DEPTH)-1:0] waddr,
   input  wire [WIDTH-1:0]         wdata,
   input  wire                     re,
   input  wire [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]        rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/psort_open.sv =====
// Open coincidence hit register and the finalize decision.
`default_nettype none
module psort_open #(
   parameter int TIME_BITS = 48
) (
   input  wire                        clock,
   input  wire                        reset,
   input  psort_pkg::cfg_type         cfg,
   input  wire                        fin_en,
   input  wire [TIME_BITS+47:0]       fin_hit,
   input  wire                        flush_clear,
   output logic                       pair,
   output logic [TIME_BITS+47:0]      open_hit
);
   import psort_pkg::*;
   localparam int TB = TIME_BITS;

   logic                 open_valid_ff, open_valid_in;
   logic [TB+47:0]       open_hit_ff, open_hit_in;
   logic [TB-1:0]        dt;
   logic [11:0]          fe;
   logic [7:0]           fr, orr, rd;
   logic                 gated, inwin, ring_ok;

   always_comb begin
      fe = fin_hit[TB+11:TB];
      fr = fin_hit[TB+47:TB+40];
      orr = open_hit_ff[TB+47:TB+40];
      gated = (fe > cfg.energy_low) && (fe < cfg.energy_high);
      dt = fin_hit[TB-1:0] - open_hit_ff[TB-1:0];
      inwin = open_valid_ff && (dt < {{(TB-24){1'b0}}, cfg.coinc_window});
      rd = (fr > orr) ? fr - orr : orr - fr;
      ring_ok = !cfg.ring_gate_enable || (rd <= cfg.max_ring_diff);
      pair = fin_en && gated && inwin && ring_ok;
      open_valid_in = open_valid_ff;
      open_hit_in = open_hit_ff;
      if (fin_en && gated) begin
         if (inwin) begin
            open_valid_in = 1'b0;
         end else begin
            open_valid_in = 1'b1;
            open_hit_in = fin_hit;
         end
      end
      if (flush_clear) begin
         open_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_valid_ff <= 1'b0;
      end else begin
         open_valid_ff <= open_valid_in;
      end
      open_hit_ff <= open_hit_in;
   end

   assign open_hit = open_hit_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/pet_coincidence_sorter.sv =====
// Top level of the PET coincidence sorter with pile-up merge.
`default_nettype none
// Takes time-ordered hits (or a flush) on req_ and gives coincidence pairs on
// rsp_, later hit first, earlier hit second with rsp_tlast high. Pending hits
// live in a RAM of PENDING_DEPTH entries that a sequencer walks one entry at a
// time (read, then evaluate and write back compacted). After the scan the hit
// is appended unless it was merged by pile-up or is a flush; if the buffer is
// full the oldest entry is first evicted and the rest shifted down. Pairs go
// out through the push states, which stall while rsp_ is not taken.
// req_tready is high only between items. There is no clearing pass: the fill
// count marks valid entries. Config is written over the APB-style csr_ port;
// the user must write it only while idle; the block does not enforce this.
module pet_coincidence_sorter #(
   parameter int PENDING_DEPTH = 16,
   parameter int TIME_BITS = 48
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // hit_time, hit_energy, detector, block, ring_index (low bit up)
   input  wire [((TIME_BITS+48+7)/8)*8-1:0]   req_tdata,
   // action: 0 hit, 1 flush
   input  wire                                req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // out_time, out_energy, out_detector, out_block, out_ring (low bit up)
   output logic [((TIME_BITS+48+7)/8)*8-1:0]  rsp_tdata,
   // pair_last
   output logic                               rsp_tlast,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [4:0]                          csr_paddr,
   input  wire [31:0]                         csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import psort_pkg::*;

   localparam int TB = TIME_BITS;
   localparam int HW = TIME_BITS + 48;
   localparam int DW = ((TIME_BITS + 48 + 7) / 8) * 8;
   localparam int AW = $clog2(PENDING_DEPTH);
   localparam int CW = $clog2(PENDING_DEPTH + 1);

   // configuration registers
   cfg_type cfg_ff, cfg_in;
   logic    csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_ENERGY_LOW:     cfg_in.energy_low = csr_pwdata[11:0];
            REG_ENERGY_HIGH:    cfg_in.energy_high = csr_pwdata[11:0];
            REG_COINC_WINDOW:   cfg_in.coinc_window = csr_pwdata[23:0];
            REG_PILEUP_WINDOW:  cfg_in.pileup_window = csr_pwdata[23:0];
            REG_MERGE_BY_BLOCK: cfg_in.merge_by_block = csr_pwdata[0];
            REG_RING_GATE_EN:   cfg_in.ring_gate_enable = csr_pwdata[0];
            REG_MAX_RING_DIFF:  cfg_in.max_ring_diff = csr_pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
      case (csr_paddr[4:2])
         REG_ENERGY_LOW:     csr_prdata = {20'd0, cfg_ff.energy_low};
         REG_ENERGY_HIGH:    csr_prdata = {20'd0, cfg_ff.energy_high};
         REG_COINC_WINDOW:   csr_prdata = {8'd0, cfg_ff.coinc_window};
         REG_PILEUP_WINDOW:  csr_prdata = {8'd0, cfg_ff.pileup_window};
         REG_MERGE_BY_BLOCK: csr_prdata = {31'd0, cfg_ff.merge_by_block};
         REG_RING_GATE_EN:   csr_prdata = {31'd0, cfg_ff.ring_gate_enable};
         REG_MAX_RING_DIFF:  csr_prdata = {24'd0, cfg_ff.max_ring_diff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.energy_low <= 12'd390;
         cfg_ff.energy_high <= 12'd600;
         cfg_ff.coinc_window <= 24'd10000;
         cfg_ff.pileup_window <= 24'd40000;
         cfg_ff.merge_by_block <= 1'b0;
         cfg_ff.ring_gate_enable <= 1'b0;
         cfg_ff.max_ring_diff <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer state
   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [CW-1:0] idx_ff, idx_in;      // next entry to read
   logic [CW-1:0] keep_ff, keep_in;    // compaction write pointer
   logic [CW-1:0] cnt_ff, cnt_in;      // fill count of the pending RAM
   logic          merged_ff, merged_in;
   logic [RES_BITS-1:0] res_ff, res_in; // results given this item
   logic [HW-1:0] hit_ff, hit_in;      // item being worked on
   logic [HW-1:0] pa_ff, pa_in;        // later hit of a pair
   logic [HW-1:0] pb_ff, pb_in;        // earlier (open) hit of a pair

   // output register
   logic          out_valid_ff, out_valid_in;
   logic [HW-1:0] out_data_ff, out_data_in;
   logic          out_last_ff, out_last_in;
   logic          out_free;

   // RAM ports
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [HW-1:0] ram_wdata, ram_rdata;

   // finalize unit
   logic          fin_en, pair, flush_clear;
   logic [HW-1:0] open_hit;

   // entry evaluation
   logic [TB-1:0] age;
   logic          expired, match;
   logic [12:0]   esum;
   logic [HW-1:0] merged_entry;

   psort_ram #(.WIDTH(HW), .DEPTH(PENDING_DEPTH)) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .re       (ram_re),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   psort_open #(.TIME_BITS(TIME_BITS)) u_open (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .fin_en      (fin_en),
      .fin_hit     (ram_rdata),
      .flush_clear (flush_clear),
      .pair        (pair),
      .open_hit    (open_hit)
   );

   always_comb begin
      age = hit_ff[TB-1:0] - ram_rdata[TB-1:0];
      expired = age >= {{(TB-24){1'b0}}, cfg_ff.pileup_window};
      match = (ram_rdata[TB+27:TB+12] == hit_ff[TB+27:TB+12]) ||
              (cfg_ff.merge_by_block &&
               (ram_rdata[TB+39:TB+28] == hit_ff[TB+39:TB+28]));
      esum = {1'b0, ram_rdata[TB+11:TB]} + {1'b0, hit_ff[TB+11:TB]};
      merged_entry = ram_rdata;
      merged_entry[TB+11:TB] = esum[12] ? ENERGY_MAX : esum[11:0];
   end

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      idx_in = idx_ff;
      keep_in = keep_ff;
      cnt_in = cnt_ff;
      merged_in = merged_ff;
      res_in = res_ff;
      hit_in = hit_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_waddr = keep_ff[AW-1:0];
      ram_raddr = idx_ff[AW-1:0];
      ram_wdata = ram_rdata;
      fin_en = 1'b0;
      flush_clear = 1'b0;
      req_tready = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               hit_in = req_tdata[HW-1:0];
               phase_in = req_tuser ? PH_FLUSH : PH_SCAN;
               idx_in = '0;
               keep_in = '0;
               merged_in = 1'b0;
               res_in = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            if (idx_ff < cnt_ff) begin
               ram_re = 1'b1;
               state_in = ST_EVAL;
            end else begin
               case (phase_ff)
                  PH_FLUSH: begin
                     cnt_in = '0;
                     flush_clear = 1'b1;
                     state_in = ST_IDLE;
                  end
                  PH_SCAN: begin
                     cnt_in = keep_ff;
                     if (merged_ff) begin
                        state_in = ST_IDLE;
                     end else if (keep_ff == CW'(PENDING_DEPTH)) begin
                        // buffer full: evict the oldest entry, then shift down
                        phase_in = PH_EVICT;
                        idx_in = '0;
                     end else begin
                        state_in = ST_APPEND;
                     end
                  end
                  default: begin
                     cnt_in = CW'(PENDING_DEPTH - 1);
                     state_in = ST_APPEND;
                  end
               endcase
            end
         end
         ST_EVAL: begin
            idx_in = idx_ff + CW'(1);
            case (phase_ff)
               PH_SCAN: begin
                  fin_en = expired;
                  if (!expired) begin
                     ram_we = 1'b1;
                     keep_in = keep_ff + CW'(1);
                     if (match && !merged_ff) begin
                        ram_wdata = merged_entry;
                        merged_in = 1'b1;
                     end
                  end
               end
               PH_FLUSH: begin
                  fin_en = 1'b1;
               end
               PH_EVICT: begin
                  fin_en = 1'b1;
                  phase_in = PH_SHIFT;
               end
               default: begin
                  ram_we = 1'b1;
                  ram_waddr = AW'(idx_ff - CW'(1));
               end
            endcase
            if (pair) begin
               pa_in = ram_rdata;
               pb_in = open_hit;
               state_in = ST_PUSH_A;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_PUSH_A: begin
            if (out_free) begin
               if (res_ff < RES_BITS'(MAX_RESULTS)) begin
                  out_valid_in = 1'b1;
                  out_data_in = pa_ff;
                  out_last_in = 1'b0;
                  res_in = res_ff + RES_BITS'(1);
               end
               state_in = ST_PUSH_B;
            end
         end
         ST_PUSH_B: begin
            if (out_free) begin
               if (res_ff < RES_BITS'(MAX_RESULTS)) begin
                  out_valid_in = 1'b1;
                  out_data_in = pb_ff;
                  out_last_in = 1'b1;
                  res_in = res_ff + RES_BITS'(1);
               end
               state_in = ST_RD;
            end
         end
         ST_APPEND: begin
            ram_we = 1'b1;
            ram_waddr = cnt_ff[AW-1:0];
            ram_wdata = hit_ff;
            cnt_in = cnt_ff + CW'(1);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_SCAN;
         idx_ff <= '0;
         keep_ff <= '0;
         cnt_ff <= '0;
         merged_ff <= 1'b0;
         res_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff <= idx_in;
         keep_ff <= keep_in;
         cnt_ff <= cnt_in;
         merged_ff <= merged_in;
         res_ff <= res_in;
         out_valid_ff <= out_valid_in;
      end
      hit_ff <= hit_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = DW'(out_data_ff);
   assign rsp_tlast = out_last_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/psort_checker.sv =====
// Port-level checker of the coincidence sorter and its bind.
`default_nettype none
module psort_checker #(
   parameter int DW = 96
) (
   input wire          clock,
   input wire          reset,
   input wire          req_tvalid,
   input wire          req_tready,
   input wire          rsp_tvalid,
   input wire          rsp_tready,
   input wire [DW-1:0] rsp_tdata,
   input wire          csr_pready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new item taken while one is at work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle and empty after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("config port stalled");
endmodule

bind pet_coincidence_sorter psort_checker #(.DW(((TIME_BITS+48+7)/8)*8)) u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
`default_nettype wire
